@@ sv/cbeq_pkg.sv @@
// Shared types and constants for the cascaded biquad equalizer.
`timescale 1ns / 1ps
package cbeq_pkg;

    localparam int BANDS        = 13;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int COEF_FRAC    = COEF_WIDTH - 4;
    localparam int COEF_SLOTS   = BANDS * 5;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 4;
    localparam int PROD_W       = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W        = PROD_W + 4;
    localparam int STEP_W       = 3;

    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_BYPASS_MASK   = 2'd1;
    localparam logic [1:0] REG_COEF_INDEX    = 2'd2;
    localparam logic [1:0] REG_COEF_VALUE    = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           last_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic [CH_W-1:0]                channel_out;
    } out_item_t;

    typedef struct packed {
        logic                           vld;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [CH_W-1:0]                ch;
    } link_t;

    typedef struct packed {
        logic                         we;
        logic [STEP_W-1:0]            k;
        logic signed [COEF_WIDTH-1:0] value;
    } coef_wr_t;

endpackage

@@ sv/cascaded_biquad_equalizer.sv @@
// Top level: APB registers, channel tracking, chain of biquad cells, result buffer.
//  channel   | direction | handshake           | payload
//  in        | in        | in_valid / in_stall   | in_data (sample_in, last_of_buffer)
//  out       | out       | out_valid / out_stall | out_data (sample_out, channel_out)
//  apb       | in        | psel/penable/pready   | paddr, pwdata, prdata
// A request passes through every band in turn; an active band runs the per-band
// multiply-accumulate sequence of its cell, while a bypassed band only registers it.
// Reset clears history, coefficients and channel position at once.
// A finished result waits in an output register; a new request is taken meanwhile.
`timescale 1ns / 1ps
module cascaded_biquad_equalizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cbeq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output cbeq_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cbeq_pkg::*;

    logic [CNT_W-1:0]       chan_count_reg;
    logic [BANDS-1:0]       bypass_reg;
    logic [6:0]             coef_index_reg;
    logic [31:0]            coef_value_reg;
    logic [CH_W-1:0]        pos_reg;
    logic                   busy_reg;
    logic                   pend_reg;
    out_item_t              pend_item_reg;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;

    link_t                  links [BANDS+1];
    coef_wr_t               coef_wr [BANDS];
    logic                   wr_en;
    logic [1:0]             reg_sel;
    logic [14:0]            band_prod;
    logic [4:0]             band_idx;
    logic [CNT_W-1:0]       count_eff;
    logic [CH_W-1:0]        ch;
    logic                   accept;
    logic                   move;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_comb
    begin
        case (reg_sel)
            REG_CHANNEL_COUNT: prdata = 32'(chan_count_reg);
            REG_BYPASS_MASK:   prdata = 32'(bypass_reg);
            REG_COEF_INDEX:    prdata = 32'(coef_index_reg);
            REG_COEF_VALUE:    prdata = coef_value_reg;
            default:           prdata = '0;
        endcase
    end

    assign band_prod = 15'(coef_index_reg) * 15'd205;
    assign band_idx  = band_prod[14:10];

    always_comb
    begin
        for (int b = 0; b < BANDS; b++)
        begin
            coef_wr[b].we    = wr_en && reg_sel == REG_COEF_VALUE &&
                               coef_index_reg < 7'(COEF_SLOTS) && band_idx == 5'(b);
            coef_wr[b].k     = STEP_W'(coef_index_reg - 7'(band_idx) * 7'd5);
            coef_wr[b].value = pwdata;
        end
        if (chan_count_reg == '0)
            count_eff = CNT_W'(1);
        else if (chan_count_reg > CNT_W'(MAX_CHANNELS))
            count_eff = CNT_W'(MAX_CHANNELS);
        else
            count_eff = chan_count_reg;
        ch = (CNT_W'(pos_reg) >= count_eff) ? '0 : pos_reg;
    end

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign move     = pend_reg && (!out_valid_reg || !out_stall);

    assign links[0].vld    = accept;
    assign links[0].sample = in_data.sample_in;
    assign links[0].ch     = ch;

    genvar g;
    generate
        for (g = 0; g < BANDS; g++)
        begin : g_cell
            cbeq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .bypass   (bypass_reg[g]),
                .coef_wr  (coef_wr[g]),
                .link_in  (links[g]),
                .link_out (links[g+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= CNT_W'(2);
            bypass_reg     <= '1;
            coef_index_reg <= '0;
            coef_value_reg <= '0;
            pos_reg        <= '0;
            busy_reg       <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_sel)
                    REG_CHANNEL_COUNT: chan_count_reg <= pwdata[CNT_W-1:0];
                    REG_BYPASS_MASK:   bypass_reg     <= pwdata[BANDS-1:0];
                    REG_COEF_INDEX:    coef_index_reg <= pwdata[6:0];
                    REG_COEF_VALUE:    coef_value_reg <= pwdata;
                    default:           ;
                endcase
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
                if (in_data.last_of_buffer || CNT_W'(ch) + CNT_W'(1) >= count_eff)
                    pos_reg <= '0;
                else
                    pos_reg <= ch + 1'b1;
            end
            if (links[BANDS].vld)
                pend_reg <= 1'b1;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (move)
            begin
                pend_reg      <= 1'b0;
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (links[BANDS].vld)
        begin
            pend_item_reg.sample_out  <= links[BANDS].sample;
            pend_item_reg.channel_out <= links[BANDS].ch;
        end
        if (move)
            out_item_reg <= pend_item_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not set after accept");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        links[BANDS].vld |-> busy_reg && !pend_reg)
        else $error("chain result without request in flight");
    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg)
        else $error("pending result while idle");
    a_move_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("result not presented");

endmodule

@@ sv/cbeq_cell.sv @@
// One biquad section: per-channel history, five coefficients, one shared multiplier.
`timescale 1ns / 1ps
module cbeq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bypass,
    input  cbeq_pkg::coef_wr_t coef_wr,
    input  cbeq_pkg::link_t   link_in,
    output cbeq_pkg::link_t   link_out
);
    import cbeq_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-COEF_FRAC-1:0] SMAX =
        (ACC_W-COEF_FRAC)'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-COEF_FRAC-1:0] SMIN = -SMAX - 1;

    logic signed [COEF_WIDTH-1:0]   coef_reg [5];
    logic signed [SAMPLE_WIDTH-1:0] x1_reg [MAX_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] x2_reg [MAX_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y1_reg [MAX_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] y2_reg [MAX_CHANNELS];
    logic                           busy_reg;
    logic [STEP_W-1:0]              step_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [CH_W-1:0]                ch_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic                           sub_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    link_t                          out_reg;

    logic signed [SAMPLE_WIDTH-1:0]        op;
    logic signed [COEF_WIDTH-1:0]          cf;
    logic signed [PROD_W-1:0]              mult;
    logic signed [ACC_W-1:0]               prod_ext;
    logic signed [ACC_W-COEF_FRAC-1:0]     shifted;
    logic signed [SAMPLE_WIDTH-1:0]        y;

    always_comb
    begin
        case (step_reg)
            3'd0:    begin op = x_reg;          cf = coef_reg[0]; end
            3'd1:    begin op = x1_reg[ch_reg]; cf = coef_reg[1]; end
            3'd2:    begin op = x2_reg[ch_reg]; cf = coef_reg[2]; end
            3'd3:    begin op = y1_reg[ch_reg]; cf = coef_reg[3]; end
            3'd4:    begin op = y2_reg[ch_reg]; cf = coef_reg[4]; end
            default: begin op = '0;             cf = '0;          end
        endcase
        mult     = PROD_W'(cf) * PROD_W'(op);
        prod_ext = ACC_W'(prod_reg);
        shifted  = (ACC_W-COEF_FRAC)'(acc_reg >>> COEF_FRAC);
        if (shifted > SMAX)
            y = SAMPLE_WIDTH'(SMAX);
        else if (shifted < SMIN)
            y = SAMPLE_WIDTH'(SMIN);
        else
            y = SAMPLE_WIDTH'(shifted);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                coef_reg[i] <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
            busy_reg <= 1'b0;
            step_reg <= '0;
            x_reg    <= '0;
            ch_reg   <= '0;
            out_reg  <= '0;
        end
        else
        begin
            if (coef_wr.we && coef_wr.k < STEP_W'(5))
                coef_reg[coef_wr.k] <= coef_wr.value;
            if (link_in.vld && bypass)
                out_reg <= link_in;
            else if (busy_reg && step_reg == 3'd6)
            begin
                out_reg.vld    <= 1'b1;
                out_reg.sample <= y;
                out_reg.ch     <= ch_reg;
            end
            else
                out_reg.vld <= 1'b0;
            if (link_in.vld && !bypass)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg    <= link_in.sample;
                ch_reg   <= link_in.ch;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == 3'd6)
                begin
                    busy_reg       <= 1'b0;
                    x2_reg[ch_reg] <= x1_reg[ch_reg];
                    x1_reg[ch_reg] <= x_reg;
                    y2_reg[ch_reg] <= y1_reg[ch_reg];
                    y1_reg[ch_reg] <= y;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mult;
        sub_reg  <= (step_reg >= 3'd3);
        if (link_in.vld)
            acc_reg <= ROUND_C;
        else if (busy_reg && step_reg >= 3'd1 && step_reg <= 3'd5)
            acc_reg <= sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
    end

    assign link_out = out_reg;

endmodule
